// ===== hw/rtl/crng_pkg.sv =====
`timescale 1ns / 1ps

package crng_pkg;

    localparam int TABLE_SIZE = 32;
    localparam int WARMUP     = 8;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int STEPS      = TABLE_SIZE + WARMUP;
    localparam int CNT_W      = $clog2(STEPS);

    localparam int GEN_W  = 31;
    localparam int MUL_W  = 16;
    localparam int PROD_W = GEN_W + MUL_W;
    localparam int FOLD_W = 8;
    localparam int TDATA_W = 32;

    localparam logic [GEN_W-1:0]  MOD_A  = 31'd2147483563;
    localparam logic [GEN_W-1:0]  MOD_B  = 31'd2147483399;
    localparam logic [MUL_W-1:0]  MUL_A  = 16'd40014;
    localparam logic [MUL_W-1:0]  MUL_B  = 16'd40692;
    localparam logic [FOLD_W-1:0] WRAP_A = 8'd85;
    localparam logic [FOLD_W-1:0] WRAP_B = 8'd249;
    localparam logic [GEN_W-1:0]  FOLD   = 31'd2147483562;

    localparam longint SLOT_DIV = 1 + longint'(FOLD) / TABLE_SIZE;

    localparam logic [GEN_W-1:0] FIRST_RESET  = 31'd1;
    localparam logic [GEN_W-1:0] SECOND_RESET = 31'd123456789;

    typedef struct packed {
        logic              load_seed;
        logic              seed_step;
        logic              seed_last;
        logic              fill_we;
        logic [SLOT_W-1:0] fill_idx;
        logic              draw_step;
        logic              draw_out;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_stall;
    } t_ctrl_stat;

endpackage

// ===== hw/rtl/crng_lcg.sv =====
`timescale 1ns / 1ps

module crng_lcg
    import crng_pkg::*;
(
    input  logic              i_clk,
    input  logic [GEN_W-1:0]  i_x,
    input  logic [MUL_W-1:0]  i_mul,
    input  logic [FOLD_W-1:0] i_wrap,
    input  logic [GEN_W-1:0]  i_mod,
    output logic [GEN_W-1:0]  o_red
);

    logic [PROD_W-1:0] r_prod;
    logic [MUL_W-1:0]  hi;
    logic [GEN_W-1:0]  lo;
    logic [GEN_W:0]    sum;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_x) * PROD_W'(i_mul);
    end

    // The modulus is 2^31 minus a small wrap constant, so the upper part folds back.
    always_comb begin
        hi  = r_prod[PROD_W-1:GEN_W];
        lo  = r_prod[GEN_W-1:0];
        sum = {1'b0, lo} + ((GEN_W+1)'(hi) * (GEN_W+1)'(i_wrap));
        if (sum >= {1'b0, i_mod}) begin
            sum = sum - {1'b0, i_mod};
        end
        o_red = sum[GEN_W-1:0];
    end

endmodule

// ===== hw/rtl/crng_datapath.sv =====
`timescale 1ns / 1ps

module crng_datapath
    import crng_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl_cmd          i_cmd,
    output t_ctrl_stat         o_stat,
    input  logic [GEN_W-1:0]   i_seed,
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata
);

    logic [GEN_W-1:0]      r_first;
    logic [GEN_W-1:0]      r_second;
    logic [GEN_W-1:0]      r_last;
    logic [GEN_W-1:0]      r_out;
    logic                  r_out_valid;
    logic [GEN_W-1:0]      r_mem [TABLE_SIZE];
    logic [TABLE_SIZE-1:0] r_valid;
    logic [GEN_W-1:0]      r_rd_data;
    logic                  r_rd_valid;
    logic [SLOT_W-1:0]     r_slot;

    logic [GEN_W-1:0]      red_a;
    logic [GEN_W-1:0]      red_b;
    logic [TABLE_SIZE-2:0] ge;
    logic [SLOT_W-1:0]     slot;
    logic [GEN_W-1:0]      entry;
    logic [GEN_W+1:0]      diff;
    logic [GEN_W-1:0]      out_val;
    logic [GEN_W-1:0]      seed_val;
    logic                  mem_we;
    logic [SLOT_W-1:0]     mem_addr;
    logic [GEN_W-1:0]      mem_wdata;

    crng_lcg u_lcg_a (
        .i_clk  (i_clk),
        .i_x    (r_first),
        .i_mul  (MUL_A),
        .i_wrap (WRAP_A),
        .i_mod  (MOD_A),
        .o_red  (red_a)
    );

    crng_lcg u_lcg_b (
        .i_clk  (i_clk),
        .i_x    (r_second),
        .i_mul  (MUL_B),
        .i_wrap (WRAP_B),
        .i_mod  (MOD_B),
        .o_red  (red_b)
    );

    // Slot selection: count the slot boundaries at or below the previous output.
    always_comb begin
        for (int k = 1; k < TABLE_SIZE; k++) begin
            ge[k-1] = ({1'b0, r_last} >= (GEN_W+1)'(k * SLOT_DIV));
        end
        slot = SLOT_W'($countones(ge));
    end

    always_comb begin
        entry = r_rd_valid ? r_rd_data : '0;
        diff  = {2'b00, entry} - {2'b00, r_second};
        if ($signed(diff) < 1) begin
            diff = diff + {2'b00, FOLD};
        end
        out_val  = diff[GEN_W-1:0];
        seed_val = (i_seed == '0) ? GEN_W'(1) : i_seed;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_slot;
        mem_wdata = r_first;
        if (i_cmd.fill_we) begin
            mem_we    = 1'b1;
            mem_addr  = i_cmd.fill_idx;
            mem_wdata = red_a;
        end else if (i_cmd.draw_out) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd_data <= r_mem[slot];
        r_slot    <= slot;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first     <= FIRST_RESET;
            r_second    <= SECOND_RESET;
            r_last      <= '0;
            r_out       <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_rd_valid <= r_valid[slot];
            if (mem_we) begin
                r_valid[mem_addr] <= 1'b1;
            end
            if (i_cmd.load_seed) begin
                r_first  <= seed_val;
                r_second <= seed_val;
            end else if (i_cmd.seed_step) begin
                r_first <= red_a;
            end else if (i_cmd.draw_step) begin
                r_first  <= red_a;
                r_second <= red_b;
            end
            if (i_cmd.seed_last) begin
                r_last <= red_a;
            end else if (i_cmd.draw_out) begin
                r_last <= out_val;
            end
            if (i_cmd.draw_out) begin
                r_out       <= out_val;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_stat.out_stall = r_out_valid && !i_m_tready;
    assign o_m_tvalid       = r_out_valid;
    assign o_m_tdata        = TDATA_W'(r_out);

endmodule

// ===== hw/rtl/crng_ctrl.sv =====
`timescale 1ns / 1ps

module crng_ctrl
    import crng_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic       i_reseed,
    input  t_ctrl_stat i_stat,
    output t_ctrl_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEED_MUL = 3'd1;
    localparam logic [2:0] S_SEED_RED = 3'd2;
    localparam logic [2:0] S_DRAW_MUL = 3'd3;
    localparam logic [2:0] S_DRAW_RED = 3'd4;
    localparam logic [2:0] S_DRAW_OUT = 3'd5;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic             accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state        = r_state;
        n_cnt          = r_cnt;
        o_cmd          = '0;
        o_cmd.fill_idx = r_cnt[SLOT_W-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_reseed) begin
                        o_cmd.load_seed = 1'b1;
                        n_cnt           = CNT_W'(STEPS - 1);
                        n_state         = S_SEED_MUL;
                    end else begin
                        n_state = S_DRAW_MUL;
                    end
                end
            end
            S_SEED_MUL: begin
                n_state = S_SEED_RED;
            end
            S_SEED_RED: begin
                o_cmd.seed_step = 1'b1;
                o_cmd.fill_we   = ({1'b0, r_cnt} < (CNT_W+1)'(TABLE_SIZE));
                if (r_cnt == '0) begin
                    o_cmd.seed_last = 1'b1;
                    n_state         = S_DRAW_MUL;
                end else begin
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_SEED_MUL;
                end
            end
            S_DRAW_MUL: begin
                n_state = S_DRAW_RED;
            end
            S_DRAW_RED: begin
                o_cmd.draw_step = 1'b1;
                n_state         = S_DRAW_OUT;
            end
            S_DRAW_OUT: begin
                if (!i_stat.out_stall) begin
                    o_cmd.draw_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ===== hw/rtl/combined_lcg_shuffle_rng_unit.sv =====
`timescale 1ns / 1ps
// A draw beat runs the multiply, fold and output states; no new beat is taken until it is done.
// A reseed beat first runs 40 warm-up and fill steps of the first generator.
// The draw rate is set by the multiply, fold and table read-modify-write done in sequence.
// Reset is synchronous and active low; it restores both generators and the previous output,
// and clears the shuffle table through per-entry valid bits.

module combined_lcg_shuffle_rng_unit
    import crng_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  logic [TDATA_W-1:0] i_s_tdata,   // [30:0] seed_magnitude, [31] zero
    input  logic               i_s_tuser,   // [0] command
    output logic               o_m_tvalid,
    input  logic               i_m_tready,
    output logic [TDATA_W-1:0] o_m_tdata    // [30:0] deviate, [31] zero
);

    t_ctrl_cmd  cmd;
    t_ctrl_stat stat;

    crng_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_reseed   (i_s_tuser),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    crng_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_seed     (i_s_tdata[GEN_W-1:0]),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

// ===== tb/combined_lcg_shuffle_rng_unit_tb.sv =====
`timescale 1ns / 1ps

module combined_lcg_shuffle_rng_unit_tb;
    import crng_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int LONG_HOLD   = 300;
    localparam int N_RANDOM    = 1700;

    localparam bit CMD_DRAW   = 1'b0;
    localparam bit CMD_RESEED = 1'b1;

    typedef struct packed {
        logic             cmd;
        logic [GEN_W-1:0] seed;
        logic             known;
        logic [GEN_W-1:0] deviate;
    } t_vec;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_s_tvalid;
    logic               o_s_tready;
    logic [TDATA_W-1:0] i_s_tdata;   // [30:0] seed_magnitude, [31] zero
    logic               i_s_tuser;   // [0] command
    logic               o_m_tvalid;
    logic               i_m_tready;
    logic [TDATA_W-1:0] o_m_tdata;   // [30:0] deviate, [31] zero

    logic [GEN_W-1:0] gen_a;
    logic [GEN_W-1:0] gen_b;
    logic [GEN_W-1:0] prev_dev;
    logic [GEN_W-1:0] shuf [TABLE_SIZE];

    logic [GEN_W-1:0] pending_deviates [$];
    t_vec             dir_rows [20];

    int  n_errors;
    int  n_checked;
    int  n_draws;
    int  n_reseeds;
    int  cycles;
    bit  no_idle;
    bit  hold_req;

    combined_lcg_shuffle_rng_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d deviates outstanding", $time,
                     pending_deviates.size());
            $display("combined_lcg_shuffle_rng_unit_tb: errors");
            $finish;
        end
    end

    function automatic logic [GEN_W-1:0] mulmod(input logic [GEN_W-1:0] x,
                                                input logic [MUL_W-1:0] m,
                                                input logic [GEN_W-1:0] md);
        logic [63:0] p;
        logic [63:0] r;
        p = {33'd0, x} * {48'd0, m};
        r = p % {33'd0, md};
        return r[GEN_W-1:0];
    endfunction

    function automatic void rng_reset();
        gen_a    = FIRST_RESET;
        gen_b    = SECOND_RESET;
        prev_dev = '0;
        for (int n = 0; n < TABLE_SIZE; n++) begin
            shuf[n] = '0;
        end
    endfunction

    function automatic logic [GEN_W-1:0] predict_deviate(input logic cmd,
                                                         input logic [GEN_W-1:0] seed);
        logic [GEN_W-1:0]  s;
        logic [63:0]       sel;
        logic [SLOT_W-1:0] slot;
        logic signed [63:0] d;
        if (cmd == CMD_RESEED) begin
            s = (seed == '0) ? GEN_W'(1) : seed;
            gen_a = s;
            gen_b = s;
            for (int n = STEPS - 1; n >= 0; n--) begin
                gen_a = mulmod(gen_a, MUL_A, MOD_A);
                if (n < TABLE_SIZE) begin
                    shuf[n] = gen_a;
                end
            end
            prev_dev = shuf[0];
        end
        gen_a = mulmod(gen_a, MUL_A, MOD_A);
        gen_b = mulmod(gen_b, MUL_B, MOD_B);
        sel = {33'd0, prev_dev} / 64'(SLOT_DIV);
        slot = (sel >= 64'(TABLE_SIZE)) ? SLOT_W'(TABLE_SIZE - 1) : sel[SLOT_W-1:0];
        d = $signed({33'd0, shuf[slot]}) - $signed({33'd0, gen_b});
        if (d < 1) begin
            d = d + $signed({33'd0, FOLD});
        end
        shuf[slot] = gen_a;
        prev_dev = d[GEN_W-1:0];
        return prev_dev;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic cmd, input logic [GEN_W-1:0] seed,
                             input logic known, input logic [GEN_W-1:0] typed_dev);
        int gap;
        logic [GEN_W-1:0] dev;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {1'b0, seed};
        do @(posedge i_clk); while (!o_s_tready);
        dev = predict_deviate(cmd, seed);
        pending_deviates.push_back(known ? typed_dev : dev);
        if (cmd == CMD_RESEED) n_reseeds++;
        else n_draws++;
        @(negedge i_clk);
    endtask

    function automatic logic [GEN_W-1:0] pick_seed();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return MOD_A;
            2: return MOD_B;
            3: return '1;
            4: return MOD_A + GEN_W'($urandom_range(1, 84));
            5: return GEN_W'($urandom_range(1, 100));
            default: return GEN_W'($urandom());
        endcase
    endfunction

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                stall = LONG_HOLD;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 8);
            end
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
                if (hold_req) hold_req = 1'b0;
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            if (pending_deviates.size() == 0) begin
                $display("%0t: unexpected deviate, expected none, actual %0d", $time,
                         o_m_tdata[GEN_W-1:0]);
                n_errors++;
            end else begin
                if (o_m_tdata[GEN_W-1:0] !== pending_deviates[0]) begin
                    $display("%0t: deviate mismatch, expected %0d, actual %0d", $time,
                             pending_deviates[0], o_m_tdata[GEN_W-1:0]);
                    n_errors++;
                end
                void'(pending_deviates.pop_front());
                n_checked++;
            end
        end
    end

    initial begin
        logic             cmd;
        logic [GEN_W-1:0] seed;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = 1'b0;
        i_m_tready = 1'b0;
        n_errors   = 0;
        n_checked  = 0;
        n_draws    = 0;
        n_reseeds  = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        rng_reset();

        // Draws from the reset state first, then the seed extremes and the moduli.
        dir_rows = '{
            '{CMD_DRAW,   31'd0,          1'b1, 31'd1407495835},
            '{CMD_DRAW,   31'h7fffffff,   1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_RESEED, 31'd0,          1'b0, 31'd0},
            '{CMD_DRAW,   31'h55555555,   1'b0, 31'd0},
            '{CMD_RESEED, 31'd1,          1'b0, 31'd0},
            '{CMD_DRAW,   31'h2aaaaaaa,   1'b0, 31'd0},
            '{CMD_RESEED, 31'd2147483563, 1'b1, 31'd2140810074},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_RESEED, 31'd2147483399, 1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_RESEED, 31'h7fffffff,   1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_RESEED, 31'd2147483562, 1'b0, 31'd0},
            '{CMD_RESEED, 31'd2147483400, 1'b0, 31'd0},
            '{CMD_RESEED, 31'd2147483564, 1'b0, 31'd0},
            '{CMD_DRAW,   31'd0,          1'b0, 31'd0},
            '{CMD_RESEED, 31'd12345,      1'b0, 31'd0}
        };

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            send_beat(dir_rows[i].cmd, dir_rows[i].seed, dir_rows[i].known,
                      dir_rows[i].deviate);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 150 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (i == 400) begin
                no_idle  = 1'b1;
                hold_req = 1'b1;
            end
            if (i == 1000) begin
                i_s_tvalid <= 1'b0;
                while (pending_deviates.size() != 0) @(negedge i_clk);
            end
            cmd  = ($urandom_range(0, 99) < 7) ? CMD_RESEED : CMD_DRAW;
            seed = (cmd == CMD_RESEED) ? pick_seed() : GEN_W'($urandom());
            send_beat(cmd, seed, 1'b0, '0);
        end
        i_s_tvalid <= 1'b0;

        while (pending_deviates.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Ran %0d draws and %0d reseeds, including seeds of zero, all ones and both moduli.",
                 n_draws, n_reseeds);
        $display("Checked %0d deviates under random source gaps, sink stalls and a long sink hold.",
                 n_checked);
        if (n_errors == 0) begin
            $display("combined_lcg_shuffle_rng_unit_tb: clean");
        end else begin
            $display("combined_lcg_shuffle_rng_unit_tb: errors");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/crng_pkg.sv
hw/rtl/crng_lcg.sv
hw/rtl/crng_datapath.sv
hw/rtl/crng_ctrl.sv
hw/rtl/combined_lcg_shuffle_rng_unit.sv
tb/combined_lcg_shuffle_rng_unit_tb.sv
